// ----- src/csgl_pkg.sv -----
// shared types, constants and helpers for the cfi sector geometry lookup
package csgl_pkg;

  // query table layout, offsets counted from query offset 0x10
  localparam int QUERY_BYTES = 45;
  localparam int IDX_W = 6;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUERY_BYTES - 1);
  localparam logic [IDX_W-1:0] SIG_LEN = 6'd5;
  localparam logic [IDX_W-1:0] OFF_SIZE_EXP = 6'h17;
  localparam logic [IDX_W-1:0] OFF_REG_COUNT = 6'h1C;
  localparam logic [IDX_W-1:0] OFF_REG_DATA = 6'h1D;
  localparam logic [7:0] MAX_SIZE_EXP = 8'd32;

  // cumulative size accumulator, wide enough for eight full regions
  localparam int ACC_W = 44;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // remainder unit: 24-bit dividend, 16-bit divisor, 4 bits per cycle
  localparam int DIVIDEND_W = 24;
  localparam int DIVISOR_W = 16;
  localparam int DIV_BITS = 4;
  localparam int DIV_CYCLES = DIVIDEND_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_CYCLES);

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MORE       = 3'd1,
    ST_BAD_SIG    = 3'd2,
    ST_BAD_COUNT  = 3'd3,
    ST_SIZE_MISM  = 3'd4,
    ST_BEYOND     = 3'd5,
    ST_NO_TABLE   = 3'd6
  } status_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  cfi_byte;
    logic [31:0] address;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIVISOR_W-1:0] rem;
  } div_rsp_t;

  // expected signature bytes: "QRY" then command set 0x0002
  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0:    b = 8'h51;
      3'd1:    b = 8'h52;
      3'd2:    b = 8'h59;
      3'd3:    b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- src/csgl_if.sv -----
// request and result channel interfaces
interface csgl_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  cfi_byte;
  logic [31:0] address;

  modport source (output valid, opcode, cfi_byte, address, input ready);
  modport sink (input valid, opcode, cfi_byte, address, output ready);
endinterface

interface csgl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] sector_start;
  logic [32:0] sector_next;

  modport source (output valid, status, sector_start, sector_next, input ready);
  modport sink (input valid, status, sector_start, sector_next, output ready);
endinterface

// ----- src/cfi_sector_geometry_lookup.sv -----
// top level of the cfi sector geometry lookup
//
// Requests arrive on items (valid/ready). opcode 0 carries the next CFI query
// byte, starting at query offset 0x10; opcode 1 asks for the sector bounds of
// address. Each request yields exactly one result on results (valid/ready):
// status, sector_start and sector_next, the two bounds zero unless a query
// answers ok.
// For a table byte before the last, a final byte with a bad signature or region
// count, or a rejected query, the result is registered as the request leaves
// the queue. Otherwise the final table byte walks the regions, forming each
// region's product and then accumulating it, and ends with a size check.
// A query walks region_count - 1 bases, then passes a set-up state, remainder
// steps of four quotient bits each and a finish state that forms the bounds;
// a zero sector size answers from the set-up state.
// Reset empties the queue, drops any table and rewinds the byte counter.
// A two-entry queue keeps accepting while a result waits to be taken; the
// back end starts no new request until its result register is free, so a
// stalled receiver fills the queue and then holds items.ready low.
module cfi_sector_geometry_lookup import csgl_pkg::*; #(
  parameter int MAX_REGIONS = 4
) (
  input  logic        clk,
  input  logic        rst,
  csgl_in_if.sink     items,
  csgl_out_if.source  results
);

  q_head_t  head;
  logic     pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  csgl_front u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .pop   (pop),
    .head  (head)
  );

  csgl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  csgl_back #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .results (results)
  );

  // back end never takes from an empty queue
  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("request taken from empty queue");

  // a sector never ends before it starts
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status == ST_OK) |->
      ({1'b0, results.sector_start} <= results.sector_next))
    else $error("sector bounds out of order");

  // only ok answers carry bounds
  a_error_bounds_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status != ST_OK) |->
      (results.sector_start == 32'd0 && results.sector_next == 33'd0))
    else $error("error result carries sector bounds");

  // the remainder unit cannot finish right after being started
  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> !div_rsp.done)
    else $error("remainder ready too early");

endmodule

// ----- src/csgl_front.sv -----
// front end: accepts requests, classifies them and queues them for the back end
module csgl_front import csgl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  csgl_in_if.sink items,
  input  logic    pop,
  output q_head_t head
);

  item_t             q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_count;
  logic              push;
  item_t             incoming;

  // classify the request by its opcode
  always_comb begin
    incoming.kind = items.opcode ? KIND_QUERY : KIND_LOAD;
    incoming.cfi_byte = items.cfi_byte;
    incoming.address = items.address;
  end

  assign items.ready = (q_count != QCNT_W'(QUEUE_DEPTH));
  assign push = items.valid && items.ready;
  assign head.valid = (q_count != '0);
  assign head.item = q_mem[rd_ptr];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        q_count <= q_count + 1'b1;
      end else if (pop && !push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= incoming;
    end
  end

endmodule

// ----- src/csgl_div.sv -----
// remainder unit: restoring division, four quotient bits per cycle
module csgl_div import csgl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                     busy;
  logic                     done;
  logic [DIV_CNT_W-1:0]     step;
  logic [DIVIDEND_W-1:0]    shreg;
  logic [DIVISOR_W-1:0]     rem;
  logic [DIVISOR_W-1:0]     divisor;
  logic [DIVIDEND_W-1:0]    sh_step;
  logic [DIVISOR_W-1:0]     rem_step;
  logic [DIVISOR_W:0]       trial;

  // one cycle worth of shift and conditional subtract
  always_comb begin
    rem_step = rem;
    sh_step = shreg;
    trial = '0;
    for (int j = 0; j < DIV_BITS; j++) begin
      trial = {rem_step, sh_step[DIVIDEND_W-1]};
      sh_step = {sh_step[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_step = trial[DIVISOR_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.rem = rem;

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg <= req.dividend;
      rem <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      shreg <= sh_step;
      rem <= rem_step;
    end
  end

endmodule

// ----- src/csgl_back.sv -----
// back end: applies table bytes, builds the region table and answers sector queries
module csgl_back import csgl_pkg::*; #(
  parameter int MAX_REGIONS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  q_head_t           head,
  output logic              pop,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp,
  csgl_out_if.source        results
);

  localparam int REG_IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int SEL_W = $clog2(MAX_REGIONS + 1);
  localparam logic [7:0] MAX_COUNT = 8'(MAX_REGIONS);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SUM_MUL   = 8'b0000_0010,
    S_SUM_ADD   = 8'b0000_0100,
    S_CHECK     = 8'b0000_1000,
    S_WALK      = 8'b0001_0000,
    S_DIV_SETUP = 8'b0010_0000,
    S_DIV_RUN   = 8'b0100_0000,
    S_FINISH    = 8'b1000_0000
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   byte_index;
  logic               signature_bad;
  logic [7:0]         size_exponent;
  logic [7:0]         region_count;
  logic               table_valid;
  logic [16:0]        cnt_tab   [MAX_REGIONS];
  logic [15:0]        units_tab [MAX_REGIONS];
  logic [32:0]        base_tab  [MAX_REGIONS];
  logic [ACC_W-1:0]   acc;
  logic [32:0]        prod;
  logic [SEL_W-1:0]   sel;
  logic [31:0]        addr_q;
  logic [32:0]        best_base;
  logic [15:0]        best_units;
  logic [7:0]         off_lo;
  logic [31:0]        start_q;
  logic               out_valid;
  status_t            out_status;
  logic [31:0]        out_start;
  logic [32:0]        out_next;

  logic               out_free;
  logic               is_load;
  logic               last_byte;
  logic [IDX_W-1:0]   rel;
  logic [3:0]         rslot;
  logic [1:0]         rk;
  logic               reg_hit;
  logic [REG_IDX_W-1:0] rix;
  logic               sig_miss;
  logic               count_bad;
  logic               beyond;
  logic [ACC_W-1:0]   target;
  logic               size_bad;
  logic [REG_IDX_W-1:0] sel_ix;
  logic [SEL_W-1:0]   sel_plus;
  logic [32:0]        offset;
  logic [7:0]         b;

  // request decode
  always_comb begin
    out_free = !out_valid || results.ready;
    pop = (state == S_IDLE) && head.valid && out_free;
    is_load = (head.item.kind == KIND_LOAD);
    b = head.item.cfi_byte;
    last_byte = (byte_index == LAST_IDX);
    rel = byte_index - OFF_REG_DATA;
    rslot = rel[5:2];
    rk = rel[1:0];
    reg_hit = (byte_index >= OFF_REG_DATA) && (int'(rslot) < MAX_REGIONS);
    rix = rslot[REG_IDX_W-1:0];
    sig_miss = (byte_index < SIG_LEN) && (b != sig_byte(byte_index[2:0]));
    count_bad = (region_count == 8'd0) || (region_count > MAX_COUNT);
    beyond = (size_exponent > MAX_SIZE_EXP) ||
             ((size_exponent != MAX_SIZE_EXP) &&
              ((head.item.address >> size_exponent[4:0]) != 32'd0));
    target = ACC_W'(33'd1 << size_exponent[5:0]);
    size_bad = (size_exponent > MAX_SIZE_EXP) || (acc != target);
    sel_ix = sel[REG_IDX_W-1:0];
    sel_plus = sel + 1'b1;
    offset = {1'b0, addr_q} - best_base;
  end

  // remainder request for the chosen region
  always_comb begin
    div_req.start = (state == S_DIV_SETUP) && (best_units != 16'd0);
    div_req.dividend = offset[31:8];
    div_req.divisor = best_units;
  end

  assign results.valid = out_valid;
  assign results.status = out_status;
  assign results.sector_start = out_start;
  assign results.sector_next = out_next;

  // sequencer, table state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      byte_index <= '0;
      signature_bad <= 1'b0;
      size_exponent <= '0;
      region_count <= '0;
      table_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop && is_load) begin
            // first byte starts a fresh table
            if (byte_index == '0) begin
              table_valid <= 1'b0;
              size_exponent <= '0;
              region_count <= '0;
              for (int r = 0; r < MAX_REGIONS; r++) begin
                cnt_tab[r] <= '0;
                units_tab[r] <= '0;
                base_tab[r] <= '0;
              end
            end
            signature_bad <= ((byte_index == '0) ? 1'b0 : signature_bad) | sig_miss;
            if (byte_index == OFF_SIZE_EXP) begin
              size_exponent <= b;
            end
            if (byte_index == OFF_REG_COUNT) begin
              region_count <= b;
            end
            // store region descriptor bytes
            if (reg_hit) begin
              unique case (rk)
                2'd0:    cnt_tab[rix] <= {9'd0, b};
                2'd1:    cnt_tab[rix] <= {1'b0, b, cnt_tab[rix][7:0]} + 17'd1;
                2'd2:    units_tab[rix] <= {8'd0, b};
                default: units_tab[rix] <= {b, units_tab[rix][7:0]};
              endcase
            end
            if (!last_byte) begin
              byte_index <= byte_index + 1'b1;
              out_valid <= 1'b1;
              out_status <= ST_MORE;
              out_start <= '0;
              out_next <= '0;
            end else begin
              byte_index <= '0;
              if (signature_bad) begin
                out_valid <= 1'b1;
                out_status <= ST_BAD_SIG;
                out_start <= '0;
                out_next <= '0;
              end else if (count_bad) begin
                out_valid <= 1'b1;
                out_status <= ST_BAD_COUNT;
                out_start <= '0;
                out_next <= '0;
              end else begin
                sel <= '0;
                acc <= '0;
                state <= S_SUM_MUL;
              end
            end
          end else if (pop) begin
            addr_q <= head.item.address;
            if (!table_valid) begin
              out_valid <= 1'b1;
              out_status <= ST_NO_TABLE;
              out_start <= '0;
              out_next <= '0;
            end else if (beyond) begin
              out_valid <= 1'b1;
              out_status <= ST_BEYOND;
              out_start <= '0;
              out_next <= '0;
            end else begin
              best_base <= base_tab[0];
              best_units <= units_tab[0];
              sel <= SEL_W'(1);
              state <= (region_count == 8'd1) ? S_DIV_SETUP : S_WALK;
            end
          end
        end
        // region base, then region size product
        S_SUM_MUL: begin
          base_tab[sel_ix] <= acc[32:0];
          prod <= {16'd0, cnt_tab[sel_ix]} * {17'd0, units_tab[sel_ix]};
          state <= S_SUM_ADD;
        end
        S_SUM_ADD: begin
          acc <= acc + ACC_W'({prod, 8'd0});
          sel <= sel_plus;
          state <= (8'(sel_plus) == region_count) ? S_CHECK : S_SUM_MUL;
        end
        // regions must add up to the chip size
        S_CHECK: begin
          out_valid <= 1'b1;
          out_start <= '0;
          out_next <= '0;
          if (size_bad) begin
            out_status <= ST_SIZE_MISM;
          end else begin
            out_status <= ST_OK;
            table_valid <= 1'b1;
          end
          state <= S_IDLE;
        end
        // last region whose base does not lie above the address
        S_WALK: begin
          if (base_tab[sel_ix] <= {1'b0, addr_q}) begin
            best_base <= base_tab[sel_ix];
            best_units <= units_tab[sel_ix];
          end
          sel <= sel_plus;
          if (8'(sel_plus) == region_count) begin
            state <= S_DIV_SETUP;
          end
        end
        S_DIV_SETUP: begin
          off_lo <= offset[7:0];
          if (best_units == 16'd0) begin
            // zero sector size collapses onto the region base
            out_valid <= 1'b1;
            out_status <= ST_OK;
            out_start <= best_base[31:0];
            out_next <= best_base;
            state <= S_IDLE;
          end else begin
            state <= S_DIV_RUN;
          end
        end
        S_DIV_RUN: begin
          if (div_rsp.done) begin
            start_q <= addr_q - {div_rsp.rem, off_lo};
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          out_valid <= 1'b1;
          out_status <= ST_OK;
          out_start <= start_q;
          out_next <= {1'b0, start_q} + {9'd0, best_units, 8'd0};
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
